FILE: design/abcg_pkg.sv
// Shared types, register indexes, reset values and sine table builder for the beep generator.
`default_nettype none

package abcg_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE,
        ST_CLASS,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } t_state;

    typedef logic [2:0] t_cfg_index;

    localparam t_cfg_index CFG_TONE_LENGTH     = 3'd0;
    localparam t_cfg_index CFG_GAP_LENGTH      = 3'd1;
    localparam t_cfg_index CFG_BEEP_COUNT      = 3'd2;
    localparam t_cfg_index CFG_CYCLE_LENGTH    = 3'd3;
    localparam t_cfg_index CFG_RAMP_LENGTH     = 3'd4;
    localparam t_cfg_index CFG_PHASE_INCREMENT = 3'd5;
    localparam t_cfg_index CFG_PEAK_AMPLITUDE  = 3'd6;

    localparam logic [15:0] RST_TONE_LENGTH     = 16'd2720;
    localparam logic [15:0] RST_GAP_LENGTH      = 16'd2080;
    localparam logic [3:0]  RST_BEEP_COUNT      = 4'd3;
    localparam logic [15:0] RST_CYCLE_LENGTH    = 16'd32000;
    localparam logic [15:0] RST_RAMP_LENGTH     = 16'd192;
    localparam logic [14:0] RST_PHASE_INCREMENT = 15'd3604;
    localparam logic [14:0] RST_PEAK_AMPLITUDE  = 15'd3276;

    // Envelope full scale in Q1.15 and the number of quotient bits per ramp division
    localparam logic [15:0] ENV_FULL  = 16'h8000;
    localparam logic [3:0]  DIV_STEPS = 4'd15;
    localparam logic [15:0] SAMPLE_MAX = 16'd32767;

    localparam longint PI_Q30 = 64'd3373259426;

    // Divide a Taylor term by (2n)(2n+1)
    function automatic longint taylor_div(longint term, int n);
        longint q;
        case (n)
            1: q = term / 6;
            2: q = term / 20;
            3: q = term / 42;
            4: q = term / 72;
            5: q = term / 110;
            6: q = term / 156;
            7: q = term / 210;
            default: q = 0;
        endcase
        return q;
    endfunction

    // Quarter-wave sine entry k in Q1.15, built by a 30-bit fixed-point Taylor series
    function automatic logic [14:0] sine_entry(int k, int tbits);
        longint x;
        longint x2;
        longint term;
        longint sum;
        longint v;
        x = (longint'(k) * PI_Q30) >>> (tbits + 1);
        x2 = (x * x) >>> 30;
        term = x;
        sum = x;
        for (int n = 1; n <= 7; n++) begin
            term = (term * x2) >>> 30;
            term = taylor_div(term, n);
            if ((n % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = (sum * 32767 + (longint'(1) <<< 29)) >>> 30;
        if (v > 32767) begin
            v = 32767;
        end
        return v[14:0];
    endfunction

endpackage

`default_nettype wire

FILE: design/alarm_beep_cadence_generator.sv
// Top level of the alarm beep cadence generator: sequencer, shared divider and sample output.
`default_nettype none

// Alarm beep cadence generator.
// Each transfer on the input stream asks for one audio sample. tdata bit 0 is the
// restart flag: when set, the cadence jumps back to sample zero before this sample.
// The output stream carries the signed sample in tdata, the last sample of each
// cadence cycle on tlast and a tone flag (inside a beep's tone) on tuser.
// Configuration registers are written over the cfg channel (index, data); write them
// only while no sample is in flight. They never stall.
// Sample flow: a tone sample inside a ramp passes from input transfer to output
// valid through edge and table lookup, classification and first multiply, 15 steps of
// the shared restoring divider that forms the ramp envelope, the envelope multiply and
// the output load; a full-scale tone sample skips the divider, and a silent sample
// skips classification, divider and multiply. One sample is in flight at a time; the
// input is ready again once the sequencer has loaded the result into the output
// register and returned to idle, so a new sample is not taken before the last is loaded.
// The output register decouples the sides: the next sample is accepted and computed
// while a finished one waits; if the receiver stalls longer, the finished sample
// holds in the sequencer until the output register frees.
// Reset (synchronous, active low) loads the default cadence and clears all counters.
module alarm_beep_cadence_generator
    import abcg_pkg::*;
#(
    parameter int PHASE_BITS      = 16,
    parameter int SINE_TABLE_BITS = 8,
    parameter int LENGTH_BITS     = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [0] restart, [7:1] zero
    // output stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,   // [15:0] sample
    output logic             o_m_axis_tlast,
    output logic [0:0]       o_m_axis_tuser,   // [0] tone_on
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire t_cfg_index  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    // Compare width wide enough for positions, lengths and tone plus gap
    localparam int CW = ((LENGTH_BITS > 16) ? LENGTH_BITS : 16) + 2;
    localparam int PW = ((PHASE_BITS > 15) ? PHASE_BITS : 15) + 1;
    localparam int TBL_SIZE = (1 << SINE_TABLE_BITS) + 1;
    localparam logic [SINE_TABLE_BITS:0] TBL_N = (SINE_TABLE_BITS + 1)'(1) << SINE_TABLE_BITS;

    // Configuration registers
    logic [15:0] r_tone_length;
    logic [15:0] r_gap_length;
    logic [3:0]  r_beep_count;
    logic [15:0] r_cycle_length;
    logic [15:0] r_ramp_length;
    logic [14:0] r_phase_increment;
    logic [14:0] r_peak_amplitude;

    // Cadence counters
    logic [LENGTH_BITS-1:0] r_cycle_position;
    logic [3:0]             r_beep_number;
    logic [LENGTH_BITS-1:0] r_beep_position;
    logic [PHASE_BITS-1:0]  r_tone_phase;

    // Per-sample working registers
    t_state                 r_state;
    t_state                 n_state;
    logic [LENGTH_BITS-1:0] r_pos;
    logic                   r_tone;
    logic                   r_last;
    logic [PHASE_BITS-1:0]  r_phase;
    logic [15:0]            r_edge;
    logic [14:0]            r_sine;
    logic                   r_neg;
    logic [29:0]            r_prod;
    logic [16:0]            r_rem;
    logic [14:0]            r_quo;
    logic [3:0]             r_cnt;
    logic [15:0]            r_env;
    logic [14:0]            r_mag;

    // Output register
    logic        r_out_valid;
    logic [15:0] r_out_sample;
    logic        r_out_last;
    logic        r_out_tone;

    logic w_in_xfer;
    logic w_out_free;
    logic w_load_out;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_load_out      = (r_state == ST_DONE) && w_out_free;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_sample;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_tone;

    // ---------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tone_length     <= RST_TONE_LENGTH;
            r_gap_length      <= RST_GAP_LENGTH;
            r_beep_count      <= RST_BEEP_COUNT;
            r_cycle_length    <= RST_CYCLE_LENGTH;
            r_ramp_length     <= RST_RAMP_LENGTH;
            r_phase_increment <= RST_PHASE_INCREMENT;
            r_peak_amplitude  <= RST_PEAK_AMPLITUDE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TONE_LENGTH:     r_tone_length     <= i_cfg_data;
                CFG_GAP_LENGTH:      r_gap_length      <= i_cfg_data;
                CFG_BEEP_COUNT:      r_beep_count      <= i_cfg_data[3:0];
                CFG_CYCLE_LENGTH:    r_cycle_length    <= i_cfg_data;
                CFG_RAMP_LENGTH:     r_ramp_length     <= i_cfg_data;
                CFG_PHASE_INCREMENT: r_phase_increment <= i_cfg_data[14:0];
                CFG_PEAK_AMPLITUDE:  r_peak_amplitude  <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Cadence counters: classify the sample and advance at the input transfer
    // ---------------------------------------------------------------
    logic                   w_restart;
    logic [LENGTH_BITS-1:0] w_cp;
    logic [3:0]             w_bn;
    logic [LENGTH_BITS-1:0] w_bp;
    logic [PHASE_BITS-1:0]  w_ph;
    logic [15:0]            w_clen_m1;
    logic                   w_last;
    logic                   w_in_beep;
    logic                   w_tone;
    logic [LENGTH_BITS-1:0] w_bp_inc;
    logic                   w_beep_wrap;
    logic [PW-1:0]          w_phase_sum;

    assign w_restart   = i_s_axis_tdata[0];
    assign w_cp        = w_restart ? '0 : r_cycle_position;
    assign w_bn        = w_restart ? '0 : r_beep_number;
    assign w_bp        = w_restart ? '0 : r_beep_position;
    assign w_ph        = w_restart ? '0 : r_tone_phase;
    // A zero cycle length behaves as one sample per cycle
    assign w_clen_m1   = (r_cycle_length == 16'd0) ? 16'd0 : r_cycle_length - 16'd1;
    assign w_last      = CW'(w_cp) >= CW'(w_clen_m1);
    assign w_in_beep   = w_bn < r_beep_count;
    assign w_tone      = w_in_beep && (CW'(w_bp) < CW'(r_tone_length));
    assign w_bp_inc    = w_bp + LENGTH_BITS'(1);
    assign w_beep_wrap = CW'(w_bp_inc) >= (CW'(r_tone_length) + CW'(r_gap_length));
    assign w_phase_sum = PW'(w_ph) + PW'(r_phase_increment);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle_position <= '0;
            r_beep_number    <= '0;
            r_beep_position  <= '0;
            r_tone_phase     <= '0;
        end else if (w_in_xfer) begin
            if (w_last) begin
                r_cycle_position <= '0;
                r_beep_number    <= '0;
                r_beep_position  <= '0;
                r_tone_phase     <= '0;
            end else begin
                r_cycle_position <= w_cp + LENGTH_BITS'(1);
                r_beep_number    <= w_bn;
                r_beep_position  <= w_bp;
                r_tone_phase     <= w_ph;
                if (w_in_beep) begin
                    if (w_beep_wrap) begin
                        r_beep_position <= '0;
                        r_tone_phase    <= '0;
                        r_beep_number   <= w_bn + 4'd1;
                    end else begin
                        r_beep_position <= w_bp_inc;
                        if (w_tone) begin
                            r_tone_phase <= w_phase_sum[PHASE_BITS-1:0];
                        end
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Quarter-wave sine table
    // ---------------------------------------------------------------
    logic [14:0]                w_rom [TBL_SIZE];
    logic [1:0]                 w_quad;
    logic [PHASE_BITS-3:0]      w_frac;
    logic [SINE_TABLE_BITS-1:0] w_idx;
    logic [SINE_TABLE_BITS:0]   w_addr;

    for (genvar k = 0; k < TBL_SIZE; k++) begin : g_rom
        localparam logic [14:0] ENTRY = sine_entry(k, SINE_TABLE_BITS);
        assign w_rom[k] = ENTRY;
    end

    assign w_quad = r_phase[PHASE_BITS-1 -: 2];
    assign w_frac = r_phase[PHASE_BITS-3:0];

    if (PHASE_BITS - 2 >= SINE_TABLE_BITS) begin : g_idx_shr
        assign w_idx = w_frac[PHASE_BITS-3 -: SINE_TABLE_BITS];
    end else begin : g_idx_shl
        assign w_idx = {w_frac, {(SINE_TABLE_BITS - PHASE_BITS + 2){1'b0}}};
    end

    // Mirror in the second and fourth quadrants
    assign w_addr = w_quad[0] ? (TBL_N - {1'b0, w_idx}) : {1'b0, w_idx};

    // ---------------------------------------------------------------
    // Envelope classification and the shared divider step
    // ---------------------------------------------------------------
    logic [15:0]   w_half_tone;
    logic [CW-1:0] w_pos_w;
    logic [CW-1:0] w_edge_w;
    logic [CW-1:0] w_tone_w;
    logic          w_attack;
    logic          w_release;
    logic [CW-1:0] w_tail;
    logic [16:0]   w_rem_sh;
    logic          w_ge;
    logic [45:0]   w_prod2;
    logic [15:0]   w_mag;

    assign w_half_tone = r_tone_length >> 1;
    assign w_pos_w     = CW'(r_pos);
    assign w_edge_w    = CW'(r_edge);
    assign w_tone_w    = CW'(r_tone_length);
    assign w_attack    = w_pos_w < w_edge_w;
    assign w_release   = w_pos_w > (w_tone_w - w_edge_w);
    assign w_tail      = w_tone_w - w_pos_w;

    // Restoring step: the numerator is below the edge, so 15 steps give the quotient
    assign w_rem_sh = {r_rem[15:0], 1'b0};
    assign w_ge     = w_rem_sh >= {1'b0, r_edge};

    assign w_prod2 = 46'(r_prod) * 46'(r_env);
    assign w_mag   = w_prod2[45:30];

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = ST_EDGE;
                end
            end
            ST_EDGE: begin
                n_state = r_tone ? ST_CLASS : ST_DONE;
            end
            ST_CLASS: begin
                n_state = (w_attack || w_release) ? ST_DIV : ST_MUL;
            end
            ST_DIV: begin
                if (r_cnt == DIV_STEPS - 4'd1) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath registers stepped by the sequencer
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    r_pos   <= w_bp;
                    r_tone  <= w_tone;
                    r_last  <= w_last;
                    r_phase <= w_ph;
                end
            end
            ST_EDGE: begin
                r_edge <= (r_ramp_length < w_half_tone) ? r_ramp_length : w_half_tone;
                r_sine <= w_rom[w_addr];
                // Negate only a nonzero tone sample in the lower half-turn
                r_neg  <= r_tone && w_quad[1] && (w_rom[w_addr] != 15'd0);
                if (!r_tone) begin
                    r_mag <= '0;
                end
            end
            ST_CLASS: begin
                r_prod <= 30'(r_sine) * 30'(r_peak_amplitude);
                r_env  <= ENV_FULL;
                r_quo  <= '0;
                r_cnt  <= '0;
                if (w_attack) begin
                    r_rem <= {1'b0, w_pos_w[15:0]};
                end else begin
                    r_rem <= {1'b0, w_tail[15:0]};
                end
            end
            ST_DIV: begin
                r_rem <= w_ge ? (w_rem_sh - {1'b0, r_edge}) : w_rem_sh;
                r_quo <= {r_quo[13:0], w_ge};
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == DIV_STEPS - 4'd1) begin
                    r_env <= {1'b0, r_quo[13:0], w_ge};
                end
            end
            ST_MUL: begin
                r_mag <= (w_mag > SAMPLE_MAX) ? SAMPLE_MAX[14:0] : w_mag[14:0];
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_sample <= r_neg ? (16'd0 - {1'b0, r_mag}) : {1'b0, r_mag};
            r_out_last   <= r_last;
            r_out_tone   <= r_tone;
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_silent_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata == 16'd0)
        else $error("silent sample is not zero");

    a_no_min_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata != 16'h8000)
        else $error("sample outside the saturated range");

    a_env_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_MUL |-> r_env <= ENV_FULL)
        else $error("envelope above full scale");

    a_start_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> r_state == ST_EDGE)
        else $error("sequencer did not start on input transfer");

endmodule

`default_nettype wire
